>>> hdl/delayed_event_slot_scheduler_assert.svh
// assertion macros shared by the scheduler modules
// each macro expects a signal named clk, and DESS_ASSERT also rst_n, in the module that uses it
`ifndef DELAYED_EVENT_SLOT_SCHEDULER_ASSERT_SVH
`define DELAYED_EVENT_SLOT_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

// checked at every rising edge outside reset
`define DESS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define DESS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DESS_ASSERT(lbl, prop, msg)
`define DESS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hdl/dess_pkg.sv
package dess_pkg;

  // command codes carried in func
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_QUEUE = 2'd2;

  // stored volume that means leave the volume alone
  localparam logic signed [15:0] VOL_NONE = -16'sd1;

  // at most this many events fire on one tick
  localparam logic [2:0] MAX_FIRE  = 3'd4;
  localparam logic [2:0] LAST_FIRE = 3'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        event_id;
    logic [15:0]        delay_ticks;
    logic signed [15:0] event_volume;
  } in_t;

  typedef struct packed {
    logic [15:0]        fired_id;
    logic signed [15:0] fired_volume;
    logic               apply_volume;
    logic [1:0]         slot_index;
    logic               last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic queue;
    logic tick_start;
    logic step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

>>> hdl/dess_dp.sv
`include "delayed_event_slot_scheduler_assert.svh"

module dess_dp #(
  parameter int NUM_SLOTS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dess_pkg::cmd_t    cmd,
  input  dess_pkg::in_t     in_item,
  output dess_pkg::status_t status,
  output logic              out_valid,
  output dess_pkg::out_t    out_item
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [15:0]        slot_id_r  [NUM_SLOTS];
  logic [15:0]        slot_id_nxt[NUM_SLOTS];
  logic signed [15:0] slot_vol_r  [NUM_SLOTS];
  logic signed [15:0] slot_vol_nxt[NUM_SLOTS];
  logic [15:0]        slot_cnt_r  [NUM_SLOTS];
  logic [15:0]        slot_cnt_nxt[NUM_SLOTS];

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [2:0]       fire_cnt_r, fire_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  dess_pkg::out_t   out_r, out_nxt;

  logic [NUM_SLOTS-1:0] due;
  logic                 later_due;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 fire;

  // due slots and whether any lies above the scan position
  always_comb begin
    later_due = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      due[i] = (slot_id_r[i] != 16'd0) && (slot_cnt_r[i] == 16'd0);
      if (due[i] && (IDX_W'(i) > idx_r)) begin
        later_due = 1'b1;
      end
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!free_found && (slot_id_r[i] == 16'd0)) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign fire = cmd.step && due[idx_r] && (fire_cnt_r < dess_pkg::MAX_FIRE);

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_id_nxt[i]  = slot_id_r[i];
      slot_vol_nxt[i] = slot_vol_r[i];
      slot_cnt_nxt[i] = slot_cnt_r[i];
    end
    idx_nxt       = idx_r;
    fire_cnt_nxt  = fire_cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    if (cmd.clear) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_id_nxt[i] = 16'd0;
      end
    end

    if (cmd.queue && free_found) begin
      slot_id_nxt[free_idx]  = in_item.event_id;
      slot_vol_nxt[free_idx] = in_item.event_volume;
      slot_cnt_nxt[free_idx] = in_item.delay_ticks;
    end

    if (cmd.tick_start) begin
      idx_nxt      = '0;
      fire_cnt_nxt = '0;
    end

    if (cmd.step) begin
      idx_nxt = IDX_W'(idx_r + 1'b1);
      if (fire) begin
        out_valid_nxt        = 1'b1;
        out_nxt.fired_id     = slot_id_r[idx_r];
        out_nxt.fired_volume = slot_vol_r[idx_r];
        out_nxt.apply_volume = (slot_vol_r[idx_r] != dess_pkg::VOL_NONE);
        out_nxt.slot_index   = 2'(idx_r);
        out_nxt.last         = (fire_cnt_r == dess_pkg::LAST_FIRE) || !later_due;
        fire_cnt_nxt         = fire_cnt_r + 3'd1;
        slot_id_nxt[idx_r]   = 16'd0;
      end else if ((slot_id_r[idx_r] != 16'd0) && (slot_cnt_r[idx_r] != 16'd0)) begin
        slot_cnt_nxt[idx_r] = slot_cnt_r[idx_r] - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_id_r[i] <= 16'd0;
      end
      idx_r       <= '0;
      fire_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_id_r[i] <= slot_id_nxt[i];
      end
      idx_r       <= idx_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_vol_r[i] <= slot_vol_nxt[i];
      slot_cnt_r[i] <= slot_cnt_nxt[i];
    end
    out_r <= out_nxt;
  end

  assign status.scan_last = (idx_r == IDX_W'(NUM_SLOTS - 1));
  assign out_valid        = out_valid_r;
  assign out_item         = out_r;

  `DESS_ASSERT(a_fire_cap, fire_cnt_r <= dess_pkg::MAX_FIRE, "fire count above limit")
  `DESS_ASSERT(a_fired_occupied, out_valid_r |-> (out_r.fired_id != 16'd0), "free slot fired")
  `DESS_ASSERT(a_fire_frees_slot, fire |=> (slot_id_r[$past(idx_r)] == 16'd0), "slot kept")

endmodule

>>> hdl/dess_ctrl.sv
`include "delayed_event_slot_scheduler_assert.svh"

module dess_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        func,
  input  dess_pkg::status_t status,
  output logic              busy,
  output dess_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd.clear      = 1'b0;
    cmd.queue      = 1'b0;
    cmd.tick_start = 1'b0;
    cmd.step       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (func)
            dess_pkg::FUNC_CLEAR: cmd.clear = 1'b1;
            dess_pkg::FUNC_QUEUE: cmd.queue = 1'b1;
            dess_pkg::FUNC_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  `DESS_ASSERT(a_tick_scans, (start && !busy && (func == dess_pkg::FUNC_TICK)) |=> busy, "no scan")
  `DESS_ASSERT(a_busy_no_write, busy |-> !(cmd.clear || cmd.queue), "slot write while scanning")
  `DESS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !busy, "busy after reset")

endmodule

>>> hdl/delayed_event_slot_scheduler.sv
// Delayed-event slot scheduler. A command beat is taken when start is high and busy is low.
// Clear and queue beats do not raise busy, so they can follow each other back to back. A
// tick beat raises busy while the datapath visits one slot per cycle from index 0 upward,
// either firing it (due and fewer than four fired so far), decrementing its counter, or
// leaving it alone. Each fired slot gives one result beat, shown on out_item for exactly one
// cycle with out_valid high, in the cycle after its slot is visited; last is set on the final
// beat of the tick. A tick with nothing due gives no beat at all. The receiver cannot stall:
// every beat must be taken in the cycle it appears. Results of a tick have all appeared by
// the first cycle in which busy is low again.
module delayed_event_slot_scheduler #(
  parameter int NUM_SLOTS = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  // command channel
  input  logic           start,
  output logic           busy,
  input  dess_pkg::in_t  in_item,
  // result channel, one beat per fired event
  output logic           out_valid,
  output dess_pkg::out_t out_item
);

  dess_pkg::cmd_t    cmd;
  dess_pkg::status_t status;

  // sequencer: idle, or walking the slot table for a tick
  dess_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .func   (in_item.func),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // slot table, scan pointer, fire counter and result register
  dess_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
